@@ src/soa_pkg.sv @@
// Shared types and constants for the slab object allocator.
// Depends on nothing; imported by slab_object_allocator.
`timescale 1ns / 1ps

package soa_pkg;

  // Heap geometry: 4 KiB pages, links kept in 16-byte granules.
  localparam int GPP        = 256;   // granules per page
  localparam int ADDR_PAGES = 64;    // pages reachable by an 18-bit offset
  localparam int LINK_W     = 15;    // stored link: index plus empty flag
  localparam int IDX_W      = 14;    // granule index
  localparam int PG_W       = 6;     // page number
  localparam int CLS_W      = 8;     // size class
  localparam int USED_W     = 9;     // objects in use per page
  localparam int EMPTY_BIT  = 14;
  localparam logic [LINK_W-1:0] EMPTY_MARK = 15'h4000;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  localparam logic CFG_LINE_LOG2  = 1'b0;
  localparam logic CFG_PAGE_COUNT = 1'b1;

  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [IDX_W-1:0]  tail;
  } cls_entry_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [USED_W-1:0] used;
  } pg_entry_t;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_INIT   = 18'h00002,
    S_A_RC   = 18'h00004,
    S_A_CK   = 18'h00008,
    S_A_PU   = 18'h00010,
    S_A_MK   = 18'h00020,
    S_C_CK   = 18'h00040,
    S_C_PU   = 18'h00080,
    S_C_LNK  = 18'h00100,
    S_C_FIN  = 18'h00200,
    S_F_RP   = 18'h00400,
    S_F_PK   = 18'h00800,
    S_F_PUSH = 18'h01000,
    S_U_RD   = 18'h02000,
    S_U_US   = 18'h04000,
    S_P_RC   = 18'h08000,
    S_P_PU   = 18'h10000,
    S_DONE   = 18'h20000
  } state_e;

endpackage

@@ src/slab_object_allocator.sv @@
// Slab object allocator: size-class free lists kept in on-chip memories.
// Depends on soa_pkg (types, codes, geometry constants).
`timescale 1ns / 1ps
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  request  | in_valid_i/in_ready_o, action_i, request_size_i,| in
//           | free_address_i                                  |
//  result   | out_valid_o/out_ready_i, object_address_o,      | out
//           | status_o                                        |
//  config   | cfg_we_i, cfg_index_i, cfg_data_i               | in
//
//  Allocate carves a fresh page into objects when its class is empty;
//  free walks the class list when a page empties (bounded by the link
//  depth), one element at a time through the single read port of the
//  link memory. One item is worked at a time.
//  Reset: list heads and page records come up empty through valid bits,
//  so there is no clearing pass; links and tails are undefined until written.
//  Stalls: the next item is taken while a result waits in the output register.

module slab_object_allocator #(
  parameter int NUM_PAGES   = 64,
  parameter int CLASS_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [12:0] request_size_i,
  input  logic [17:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] object_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import soa_pkg::*;

  // Smallest line log2 whose class count fits the class table.
  function automatic int lg_min_f(input int cs);
    int lg;
    lg = 4;
    while ((4096 >> lg) > cs) lg++;
    return lg;
  endfunction

  localparam int LP      = (NUM_PAGES < ADDR_PAGES) ? NUM_PAGES : ADDR_PAGES;
  localparam int DEPTH   = LP * GPP;
  localparam int LW      = $clog2(DEPTH);
  localparam int PW      = (LP > 1) ? $clog2(LP) : 1;
  localparam int CW      = $clog2(CLASS_SLOTS);
  localparam int CNT_W   = $clog2(DEPTH + 2);
  localparam int LG_MIN  = lg_min_f(CLASS_SLOTS);
  localparam logic [LINK_W-1:0] DEPTH_V  = LINK_W'(DEPTH);
  localparam logic [6:0]        LP_V     = 7'(LP);
  localparam logic [CNT_W-1:0]  CNT_INIT = CNT_W'(DEPTH + 1);

  function automatic logic lv(input logic [LINK_W-1:0] v);
    return !v[EMPTY_BIT] && ({1'b0, v[IDX_W-1:0]} < DEPTH_V);
  endfunction

  // Memories
  logic [LINK_W-1:0] link_mem [DEPTH];
  cls_entry_t        cls_mem  [CLASS_SLOTS];
  pg_entry_t         pg_mem   [LP];

  logic [LINK_W-1:0] link_rd_q;
  cls_entry_t        cls_rd_q;
  pg_entry_t         pg_rd_q;
  logic [CW-1:0]     cls_ra_q;
  logic [PW-1:0]     pg_ra_q;

  logic              link_we;
  logic [LW-1:0]     link_waddr, link_raddr;
  logic [LINK_W-1:0] link_wdata;
  logic              cls_we;
  logic [CW-1:0]     cls_waddr, cls_raddr;
  cls_entry_t        cls_wdata;
  logic              pg_we;
  logic [PW-1:0]     pg_waddr, pg_raddr;
  pg_entry_t         pg_wdata;
  logic              vld_clr;

  logic [CLASS_SLOTS-1:0] hv_q;
  logic [LP-1:0]          pv_q;

  // Control and working registers
  state_e            state_q, state_d;
  logic [3:0]        cfg_lg_q, cfg_lg_d, lg_q, lg_d;
  logic [6:0]        cfg_pc_q, cfg_pc_d, heap_q, heap_d;
  logic              out_valid_q, out_valid_d;
  logic [17:0]       out_addr_q, out_addr_d;
  logic [1:0]        out_st_q, out_st_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [6:0]        i_q, i_d;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [8:0]        step_q, step_d, off_q, off_d;
  logic [IDX_W-1:0]  idx_q, idx_d, fidx_q, fidx_d, wt_q, wt_d;
  logic [PG_W-1:0]   pg_q, pg_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [LINK_W-1:0] wh_q, wh_d, prev_q, prev_d, cur_q, cur_d;
  logic [17:0]       addr_q, addr_d;
  status_e           st_q, st_d;

  // Helpers
  logic [LINK_W-1:0] link_nx, head_sel;
  pg_entry_t         pe_sel;
  logic [3:0]        lg_clamp;
  logic [13:0]       mask14, sum14;
  logic [8:0]        lines, classes;
  logic [12:0]       step_w;
  logic [CLS_W-1:0]  cls_new;
  logic [IDX_W-1:0]  i_ix, i_nx_ix, tail_init, pg_base, cur_ix, nxt_ix, step_ix;
  logic [6:0]        i_nx, hm1;
  logic [9:0]        nxt_off;
  logic              more, two;
  logic [USED_W-1:0] used_dec;
  logic [PG_W-1:0]   wh_pg, idx_pg;
  logic [IDX_W-1:0]  prev_ix, head_ix;
  logic [PG_W-1:0]   cur_pg;

  assign link_nx   = lv(link_rd_q) ? link_rd_q : EMPTY_MARK;
  assign head_sel  = hv_q[cls_ra_q] ? cls_rd_q.head : EMPTY_MARK;
  assign pe_sel    = pv_q[pg_ra_q] ? pg_rd_q : '0;
  assign mask14    = (14'd1 << lg_q) - 14'd1;
  assign sum14     = {1'b0, request_size_i} + mask14;
  assign lines     = 9'(sum14 >> lg_q);
  assign classes   = 9'(9'd256 >> (lg_q - 4'd4));
  assign cls_new   = (lines == classes) ? '0 : lines[7:0];
  assign step_w    = {4'd0, lines} << (lg_q - 4'd4);
  assign i_nx      = i_q + 7'd1;
  assign hm1       = heap_q - 7'd1;
  assign i_ix      = {i_q[5:0], 8'h00};
  assign i_nx_ix   = {i_nx[5:0], 8'h00};
  assign tail_init = {hm1[5:0], 8'h00};
  assign pg_base   = {pg_q, 8'h00};
  assign cur_ix    = idx_q + IDX_W'(off_q);
  assign nxt_off   = {1'b0, off_q} + {1'b0, step_q};
  assign more      = (nxt_off + {1'b0, step_q}) <= 10'd256;
  assign nxt_ix    = idx_q + IDX_W'(nxt_off);
  assign step_ix   = idx_q + IDX_W'(step_q);
  assign two       = {step_q, 1'b0} <= 10'd256;
  assign used_dec  = used_q - 9'd1;
  assign wh_pg     = wh_q[13:8];
  assign idx_pg    = idx_q[13:8];
  assign cur_pg    = cur_q[13:8];
  assign prev_ix   = prev_q[IDX_W-1:0];
  assign head_ix   = head_sel[IDX_W-1:0];

  always_comb begin
    lg_clamp = cfg_lg_q;
    if (cfg_lg_q < 4'd4) lg_clamp = 4'd4;
    if (cfg_lg_q > 4'd8) lg_clamp = 4'd8;
    if (lg_clamp < 4'(LG_MIN)) lg_clamp = 4'(LG_MIN);
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign object_address_o = out_addr_q;
  assign status_o         = out_st_q;

  always_comb begin
    state_d  = state_q;
    cfg_lg_d = cfg_lg_q;
    cfg_pc_d = cfg_pc_q;
    lg_d     = lg_q;
    heap_d   = heap_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    cnt_d  = cnt_q;   i_d    = i_q;    cls_d  = cls_q;  step_d = step_q;
    off_d  = off_q;   idx_d  = idx_q;  fidx_d = fidx_q; wt_d   = wt_q;
    pg_d   = pg_q;    used_d = used_q; wh_d   = wh_q;   prev_d = prev_q;
    cur_d  = cur_q;   addr_d = addr_q; st_d   = st_q;
    link_we = 1'b0; link_waddr = '0; link_wdata = EMPTY_MARK; link_raddr = '0;
    cls_we  = 1'b0; cls_waddr  = '0; cls_wdata  = '0;         cls_raddr  = '0;
    pg_we   = 1'b0; pg_waddr   = '0; pg_wdata   = '0;         pg_raddr   = '0;
    vld_clr = 1'b0;

    // Take register writes at any time; init latches them into the heap setup.
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_LINE_LOG2) cfg_lg_d = cfg_data_i[3:0];
      else cfg_pc_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d = '0;
          st_d   = ST_OK;
          cls_d  = cls_new;
          step_d = step_w[8:0];
          pg_d   = free_address_i[17:12];
          fidx_d = free_address_i[17:4];
          case (action_e'(action_i))
            ACT_INIT: begin
              // Latch the registers and drop every list head and page record.
              lg_d    = lg_clamp;
              heap_d  = (cfg_pc_q > LP_V) ? LP_V : cfg_pc_q;
              vld_clr = 1'b1;
              i_d     = '0;
              state_d = S_INIT;
            end
            ACT_ALLOC: begin
              if (request_size_i == 13'd0 || request_size_i > 13'd4096) begin
                st_d    = ST_BAD_SIZE;
                state_d = S_DONE;
              end else begin
                state_d = S_A_RC;
              end
            end
            ACT_FREE: begin
              if ({1'b0, free_address_i[17:12]} >= heap_q) begin
                st_d    = ST_OUTSIDE;
                state_d = S_DONE;
              end else begin
                state_d = S_F_RP;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // Chain the heap pages onto the page list, one link per cycle.
      S_INIT: begin
        if (i_q < heap_q) begin
          link_we    = 1'b1;
          link_waddr = i_ix[LW-1:0];
          link_wdata = (i_nx == heap_q) ? EMPTY_MARK : LINK_W'(i_nx_ix);
          i_d        = i_nx;
        end else begin
          cls_we         = 1'b1;
          cls_waddr      = '0;
          cls_wdata.head = (heap_q != 7'd0) ? '0 : EMPTY_MARK;
          cls_wdata.tail = tail_init;
          state_d        = S_DONE;
        end
      end

      S_A_RC: begin
        cls_raddr = cls_q[CW-1:0];
        state_d   = S_A_CK;
      end

      S_A_CK: begin
        if (cls_q != '0 && !lv(head_sel)) begin
          cls_raddr = '0;
          state_d   = S_C_CK;
        end else if (!lv(head_sel)) begin
          st_d    = ST_NO_MEM;
          state_d = S_DONE;
        end else begin
          wh_d       = head_sel;
          wt_d       = cls_rd_q.tail;
          link_raddr = head_sel[LW-1:0];
          state_d    = S_A_PU;
        end
      end

      // Pop the head: its link becomes the new head.
      S_A_PU: begin
        cls_we         = 1'b1;
        cls_waddr      = cls_q[CW-1:0];
        cls_wdata.head = link_nx;
        cls_wdata.tail = wt_q;
        idx_d          = wh_q[IDX_W-1:0];
        pg_raddr       = wh_pg[PW-1:0];
        state_d        = S_A_MK;
      end

      S_A_MK: begin
        pg_we         = 1'b1;
        pg_waddr      = idx_pg[PW-1:0];
        pg_wdata.cls  = cls_q;
        pg_wdata.used = pe_sel.used + 9'd1;
        addr_d        = {idx_q, 4'h0};
        state_d       = S_DONE;
      end

      // Class empty: take the first free page.
      S_C_CK: begin
        if (!lv(head_sel)) begin
          st_d    = ST_NO_MEM;
          state_d = S_DONE;
        end else begin
          idx_d      = head_ix;
          wt_d       = cls_rd_q.tail;
          link_raddr = head_sel[LW-1:0];
          state_d    = S_C_PU;
        end
      end

      S_C_PU: begin
        cls_we         = 1'b1;
        cls_waddr      = '0;
        cls_wdata.head = link_nx;
        cls_wdata.tail = wt_q;
        off_d          = '0;
        state_d        = S_C_LNK;
      end

      // Carve the page into objects in address order.
      S_C_LNK: begin
        link_we    = 1'b1;
        link_waddr = cur_ix[LW-1:0];
        link_wdata = more ? LINK_W'(nxt_ix) : EMPTY_MARK;
        if (more) begin
          off_d = nxt_off[8:0];
        end else begin
          wt_d    = cur_ix;
          state_d = S_C_FIN;
        end
      end

      // Hand out the first object; the second, if any, heads the class.
      S_C_FIN: begin
        cls_we         = 1'b1;
        cls_waddr      = cls_q[CW-1:0];
        cls_wdata.head = two ? LINK_W'(step_ix) : EMPTY_MARK;
        cls_wdata.tail = wt_q;
        pg_we          = 1'b1;
        pg_waddr       = idx_pg[PW-1:0];
        pg_wdata.cls   = cls_q;
        pg_wdata.used  = 9'd1;
        addr_d         = {idx_q, 4'h0};
        state_d        = S_DONE;
      end

      S_F_RP: begin
        pg_raddr = pg_q[PW-1:0];
        state_d  = S_F_PK;
      end

      S_F_PK: begin
        cls_d     = pe_sel.cls;
        used_d    = pe_sel.used;
        idx_d     = (pe_sel.cls == '0) ? pg_base : fidx_q;
        cls_raddr = pe_sel.cls[CW-1:0];
        state_d   = S_F_PUSH;
      end

      // Push the object to the front of its class; a page with no class pushes its base onto the page list.
      S_F_PUSH: begin
        link_we        = 1'b1;
        link_waddr     = idx_q[LW-1:0];
        link_wdata     = head_sel;
        cls_we         = 1'b1;
        cls_waddr      = cls_q[CW-1:0];
        cls_wdata.head = LINK_W'(idx_q);
        cls_wdata.tail = lv(head_sel) ? cls_rd_q.tail : idx_q;
        wh_d           = LINK_W'(idx_q);
        wt_d           = lv(head_sel) ? cls_rd_q.tail : idx_q;
        if (cls_q == '0) begin
          state_d = S_DONE;
        end else if (used_dec != '0) begin
          pg_we         = 1'b1;
          pg_waddr      = pg_q[PW-1:0];
          pg_wdata.cls  = cls_q;
          pg_wdata.used = used_dec;
          state_d       = S_DONE;
        end else begin
          prev_d  = EMPTY_MARK;
          cur_d   = LINK_W'(idx_q);
          cnt_d   = CNT_INIT;
          state_d = S_U_RD;
        end
      end

      // Walk the class list and unlink every object of the emptied page.
      S_U_RD: begin
        if (lv(cur_q) && cnt_q != '0) begin
          cnt_d      = cnt_q - CNT_W'(1);
          link_raddr = cur_q[LW-1:0];
          state_d    = S_U_US;
        end else begin
          cls_we         = 1'b1;
          cls_waddr      = cls_q[CW-1:0];
          cls_wdata.head = wh_q;
          cls_wdata.tail = lv(prev_q) ? prev_ix : wt_q;
          state_d        = S_P_RC;
        end
      end

      S_U_US: begin
        if (cur_pg == pg_q) begin
          if (lv(prev_q)) begin
            link_we    = 1'b1;
            link_waddr = prev_q[LW-1:0];
            link_wdata = link_nx;
          end else begin
            wh_d = link_nx;
          end
        end else begin
          prev_d = cur_q;
        end
        cur_d   = link_nx;
        state_d = S_U_RD;
      end

      S_P_RC: begin
        cls_raddr = '0;
        pg_we     = 1'b1;
        pg_waddr  = pg_q[PW-1:0];
        pg_wdata  = '0;
        state_d   = S_P_PU;
      end

      // Return the whole page to the front of the page list.
      S_P_PU: begin
        link_we        = 1'b1;
        link_waddr     = pg_base[LW-1:0];
        link_wdata     = head_sel;
        cls_we         = 1'b1;
        cls_waddr      = '0;
        cls_wdata.head = LINK_W'(pg_base);
        cls_wdata.tail = lv(head_sel) ? cls_rd_q.tail : pg_base;
        state_d        = S_DONE;
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = (st_q == ST_OK) ? addr_q : '0;
          out_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (cls_we)  cls_mem[cls_waddr]   <= cls_wdata;
    if (pg_we)   pg_mem[pg_waddr]     <= pg_wdata;
    link_rd_q <= link_mem[link_raddr];
    cls_rd_q  <= cls_mem[cls_raddr];
    pg_rd_q   <= pg_mem[pg_raddr];
    cls_ra_q  <= cls_raddr;
    pg_ra_q   <= pg_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
      pv_q <= '0;
    end else begin
      if (vld_clr) begin
        hv_q <= '0;
        pv_q <= '0;
      end else begin
        if (cls_we) hv_q[cls_waddr] <= 1'b1;
        if (pg_we)  pv_q[pg_waddr]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_lg_q    <= 4'd4;
      cfg_pc_q    <= 7'd64;
      lg_q        <= 4'd4;
      heap_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_lg_q    <= cfg_lg_d;
      cfg_pc_q    <= cfg_pc_d;
      lg_q        <= lg_d;
      heap_q      <= heap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
    cnt_q  <= cnt_d;   i_q    <= i_d;    cls_q  <= cls_d;  step_q <= step_d;
    off_q  <= off_d;   idx_q  <= idx_d;  fidx_q <= fidx_d; wt_q   <= wt_d;
    pg_q   <= pg_d;    used_q <= used_d; wh_q   <= wh_d;   prev_q <= prev_d;
    cur_q  <= cur_d;   addr_q <= addr_d; st_q   <= st_d;
  end

  // Assertions
  a_done_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || out_ready_i)) |=> out_valid_o)
    else $error("finished item not presented");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (object_address_o == '0))
    else $error("failed item carries an address");

  a_heap_lim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_q <= LP_V)
    else $error("heap size beyond page store");

  a_lg_lim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lg_q >= 4'd4 && lg_q <= 4'd8))
    else $error("line log2 out of range");

  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_U_US) |-> (cnt_q < CNT_INIT))
    else $error("unlink walk past its bound");

endmodule
